[design/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Character codes with special handling
    localparam logic [7:0]  CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CODE_BACKSPACE = 8'h08;

    // Cell images: blank after reset, clear and scroll; erased by backspace
    localparam logic [15:0] BLANK_CELL     = 16'h0020;
    localparam logic [15:0] ERASED_CELL    = 16'h0F20;

    // Beat payload widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 32;

    // Command codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // Control sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_RETRY,
        S_RESP
    } state_t;

    // Where the reported cell value comes from
    typedef enum logic [1:0] {
        CELL_ZERO,
        CELL_BLANK,
        CELL_MEM
    } cell_src_t;

endpackage

`default_nettype wire

[design/tcw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/text_console_writer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a ROWS x COLUMNS screen of 16-bit cells (character in the
// low byte, color in the high byte) kept in one single-port-write RAM, plus a
// cursor. Mode 0 prints a character (newline and backspace handled), mode 1
// reads one cell, mode 2 clears the screen and homes the cursor. Every command
// returns one beat with the cell value, the cursor and a scroll flag. Screen rows
// live in the RAM as a ring: a scroll moves the ring's top pointer and marks the
// new bottom row blank, and a clear marks every row blank; a per-row valid flag
// makes a blank row read as space with color zero. No clearing pass runs after
// reset. An accepted command moves to the response state, which registers the
// result beat once the output register is free. A put that writes into a row
// still marked blank first fills that row in the RAM, one cell per cycle. The
// next beat is accepted as soon as the result is in the output register.
module text_console_writer #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: mode[1:0], char_code[9:2], color[17:10], read_row[22:18],
    //          read_col[29:23], zero fill[31:30]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: cell_value[15:0], cursor_row[20:16], cursor_col[27:21],
    //          scrolled[28], zero fill[31:29]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [tcw_pkg::M_TDATA_W-1:0]   m_tdata
);

    import tcw_pkg::*;

    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned CELLS  = ROWS * COLUMNS;
    localparam int unsigned ADDR_W = $clog2(CELLS);

    // Ring position of a screen row
    function automatic logic [ROW_W-1:0] row_phys(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
        logic [ROW_W:0] sum;
        sum = {1'b0, r} + {1'b0, t};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Linear RAM address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS));
        return ADDR_W'(base + ADDR_W'(c));
    endfunction

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROWS-1:0]   row_valid_reg, row_valid_next;
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    logic [COL_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic              scrolled_reg, scrolled_next;
    cell_src_t         cell_src_reg, cell_src_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Held command for the fill and retry path
    logic [S_TDATA_W-1:0] item_reg;

    logic [S_TDATA_W-1:0] item;
    logic [1:0]        it_mode;
    logic [7:0]        it_char;
    logic [7:0]        it_color;
    logic [4:0]        it_rrow;
    logic [6:0]        it_rcol;
    logic [7:0]        rrow_ext;
    logic [7:0]        rcol_ext;
    logic [7:0]        row_out_ext;
    logic [7:0]        col_out_ext;
    logic              exec_en;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  rd_phys;
    logic [ROW_W-1:0]  top_inc;
    logic              out_free;
    logic [15:0]       cell_value;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command fields: live beat when idle, held copy on retry
    assign item     = (state_reg == S_IDLE) ? s_tdata : item_reg;
    assign it_mode  = item[1:0];
    assign it_char  = item[9:2];
    assign it_color = item[17:10];
    assign it_rrow  = item[22:18];
    assign it_rcol  = item[29:23];
    assign rrow_ext = {3'b000, it_rrow};
    assign rcol_ext = {1'b0, it_rcol};

    assign s_tready = (state_reg == S_IDLE);
    assign exec_en  = (state_reg == S_IDLE && s_tvalid) || (state_reg == S_RETRY);
    assign cur_phys = row_phys(cur_row_reg, top_reg);
    assign rd_phys  = row_phys(rrow_ext[ROW_W-1:0], top_reg);
    assign top_inc  = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);
    assign out_free = !m_valid_reg || m_tready;

    // Reported cell
    always_comb begin
        case (cell_src_reg)
            CELL_MEM:   cell_value = ram_rdata;
            CELL_BLANK: cell_value = BLANK_CELL;
            default:    cell_value = '0;
        endcase
    end

    assign row_out_ext = 8'(cur_row_reg);
    assign col_out_ext = 8'(cur_col_reg);

    // Command execution, row fill and result hand-off
    always_comb begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        fill_row_next  = fill_row_reg;
        fill_cnt_next  = fill_cnt_reg;
        scrolled_next  = scrolled_reg;
        cell_src_next  = cell_src_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cell_addr(cur_phys, cur_col_reg);
        ram_wdata      = BLANK_CELL;
        ram_re         = 1'b0;
        ram_raddr      = cell_addr(rd_phys, rcol_ext[COL_W-1:0]);

        unique case (state_reg)
            S_IDLE, S_RETRY: begin
                if (exec_en) begin
                    state_next    = S_RESP;
                    scrolled_next = 1'b0;
                    cell_src_next = CELL_ZERO;
                    case (it_mode)
                        MODE_PUT: begin
                            if (it_char == CODE_NEWLINE) begin
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_W'(ROWS - 1)) begin
                                    top_next                = top_inc;
                                    row_valid_next[top_reg] = 1'b0;
                                    scrolled_next           = 1'b1;
                                end else begin
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                end
                            end else if (it_char == CODE_BACKSPACE) begin
                                if (cur_col_reg != '0) begin
                                    if (!row_valid_reg[cur_phys]) begin
                                        state_next    = S_FILL;
                                        fill_row_next = cur_phys;
                                        fill_cnt_next = '0;
                                    end else begin
                                        ram_we       = 1'b1;
                                        ram_waddr    = cell_addr(cur_phys,
                                                           cur_col_reg - COL_W'(1));
                                        ram_wdata    = ERASED_CELL;
                                        cur_col_next = cur_col_reg - COL_W'(1);
                                    end
                                end
                            end else begin
                                if (!row_valid_reg[cur_phys]) begin
                                    state_next    = S_FILL;
                                    fill_row_next = cur_phys;
                                    fill_cnt_next = '0;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {it_color, it_char};
                                    if (cur_col_reg == COL_W'(COLUMNS - 1)) begin
                                        cur_col_next = '0;
                                        if (cur_row_reg == ROW_W'(ROWS - 1)) begin
                                            top_next                = top_inc;
                                            row_valid_next[top_reg] = 1'b0;
                                            scrolled_next           = 1'b1;
                                        end else begin
                                            cur_row_next = cur_row_reg + ROW_W'(1);
                                        end
                                    end else begin
                                        cur_col_next = cur_col_reg + COL_W'(1);
                                    end
                                end
                            end
                        end
                        MODE_READ: begin
                            if (rrow_ext < 8'(ROWS) && rcol_ext < 8'(COLUMNS)) begin
                                if (row_valid_reg[rd_phys]) begin
                                    ram_re        = 1'b1;
                                    cell_src_next = CELL_MEM;
                                end else begin
                                    cell_src_next = CELL_BLANK;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            row_valid_next = '0;
                            top_next       = '0;
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(fill_row_reg, fill_cnt_reg);
                ram_wdata = BLANK_CELL;
                if (fill_cnt_reg == COL_W'(COLUMNS - 1)) begin
                    row_valid_next[fill_row_reg] = 1'b1;
                    state_next                   = S_RETRY;
                end else begin
                    fill_cnt_next = fill_cnt_reg + COL_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, scrolled_reg, col_out_ext[6:0],
                                    row_out_ext[4:0], cell_value};
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_tdata;
        end
        fill_row_reg <= fill_row_next;
        fill_cnt_reg <= fill_cnt_next;
        scrolled_reg <= scrolled_next;
        cell_src_reg <= cell_src_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Cursor and ring top stay on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (8'(cur_col_reg) < 8'(COLUMNS)) && (8'(cur_row_reg) < 8'(ROWS))
            && (8'(top_reg) < 8'(ROWS)))
        else $error("cursor or ring top out of range");

    // An accepted beat always leaves idle
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted command did not start");

    // A row fill only targets a row still marked blank
    a_fill_blank_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> !row_valid_reg[fill_row_reg])
        else $error("row fill on a row already valid");

    // The retry after a fill finds the cursor row valid
    a_retry_row_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RETRY) |-> row_valid_reg[cur_phys])
        else $error("retry on a blank row");

    // No RAM write while handing off a result
    a_no_write_in_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP) |-> !ram_we)
        else $error("RAM write during result hand-off");
`endif

endmodule

`default_nettype wire
